// ===== hdl/ftpq_pkg.sv =====
// Shared types and constants for the float to PCM quantiser
`timescale 1ns / 1ps
`default_nettype none
package ftpq_pkg;

	typedef enum logic [1:0] {
		FMT_FLOAT = 2'd0,
		FMT_S32   = 2'd1,
		FMT_S24   = 2'd2,
		FMT_S16   = 2'd3
	} fmt_t;

	localparam logic [1:0] REG_OUT_FMT = 2'd0;

	typedef struct packed {
		logic        neg;
		logic [7:0]  expo;
		logic [22:0] man;
	} f32_t;

endpackage
`default_nettype wire

// ===== hdl/ftpq_quant.sv =====
// Combinational scale, round-to-nearest-even and saturate of one float sample, with mute and float passthrough
`timescale 1ns / 1ps
`default_nettype none
module ftpq_quant
	import ftpq_pkg::*;
(
	input  wire logic [31:0] sample_bits,
	input  wire logic        mute,
	input  wire fmt_t        fmt,
	output logic      [31:0] pcm_word
);

	f32_t        f;
	logic [23:0] m;
	logic [8:0]  e_off;     // biased exponent, with 1 for zero and subnormals
	logic [4:0]  k;
	logic signed [9:0] sh;
	logic [5:0]  n;
	logic [55:0] wide;
	logic [55:0] shl;
	logic [31:0] q;
	logic        g, st, rnd_up, sat;
	logic [32:0] mag;
	logic [32:0] pos_lim, neg_lim;
	logic [31:0] qv;

	always_comb begin
		f = f32_t'(sample_bits);
		m = (f.expo == 8'd0) ? {1'b0, f.man} : {1'b1, f.man};
		unique case (fmt)
			FMT_S32: k = 5'd31;
			FMT_S24: k = 5'd23;
			default: k = 5'd15;
		endcase
		e_off = (f.expo == 8'd0) ? 9'd1 : {1'b0, f.expo};
		sh = $signed({1'b0, e_off}) - 10'sd150 + $signed({5'd0, k});
		n = 6'd0;
		wide = '0;
		shl = '0;
		q = '0;
		g = 1'b0;
		st = 1'b0;
		sat = 1'b0;
		if (f.expo == 8'hFF || sh >= 10'sd32) begin
			sat = 1'b1;
		end else if (sh >= 10'sd0) begin
			shl = {32'd0, m} << sh[4:0];
			q = shl[31:0];
			// anything above bit 31 is far past every limit
			sat = |shl[55:32];
		end else if (sh >= -10'sd25) begin
			n = 6'(-sh);
			// keep 24 fraction bits below the point
			wide = {8'd0, m, 24'd0} >> n;
			q = wide[55:24];
			g = wide[23];
			st = |wide[22:0];
		end
		rnd_up = g & (st | q[0]);
		pos_lim = (33'd1 << k) - 33'd1;
		neg_lim = 33'd1 << k;
		mag = sat ? neg_lim : ({1'b0, q} + {32'd0, rnd_up});
		if (f.neg) begin
			if (mag > neg_lim) mag = neg_lim;
			qv = 32'd0 - mag[31:0];
		end else begin
			if (mag > pos_lim) mag = pos_lim;
			qv = mag[31:0];
		end
		if (f.expo == 8'hFF && f.man != 23'd0) qv = '0;
		if (mute) pcm_word = '0;
		else if (fmt == FMT_FLOAT) pcm_word = sample_bits;
		else pcm_word = qv;
	end

endmodule
`default_nettype wire

// ===== hdl/float_to_pcm_quantizer_core.sv =====
// Top level: APB register, input register, quantiser and output skid
// An accepted input beat is registered in stage 1, quantised, then registered in stage 2 (via the skid if stalled).
// Throughput: one beat per cycle while in_stall is low; a stalled output still takes one beat into a skid slot.
// The single quantiser between input and result register sets the rate.
// Reset: arst_n clears valids and the output format to float passthrough.
`timescale 1ns / 1ps
`default_nettype none
module float_to_pcm_quantizer_core
	import ftpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [1:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] sample_bits,
	input  wire logic        mute,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] pcm_word
);

	fmt_t        fmt_q;
	logic        v_s1, v_s2, skid_v_q;
	logic [31:0] bits_s1, word_s2, skid_q, qword;
	logic        mute_s1, adv;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_OUT_FMT) ? {30'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fmt_q <= FMT_FLOAT;
		else if (psel && penable && pwrite && paddr == REG_OUT_FMT)
			fmt_q <= fmt_t'(pwdata[1:0]);
	end

	// stage 2 is free when empty or being taken; skid absorbs one beat
	assign adv = !v_s2 || !out_stall;
	assign in_stall = skid_v_q;

	ftpq_quant u_quant (
		.sample_bits(bits_s1), .mute(mute_s1), .fmt(fmt_q), .pcm_word(qword)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s2 <= skid_v_q | v_s1;
				v_s1 <= in_valid & !in_stall;
				// a full skid drains to stage 2 and takes the stage 1 beat
				skid_v_q <= skid_v_q & v_s1;
			end else if (!skid_v_q) begin
				// hold stage 2, park stage 1 result in skid
				skid_v_q <= v_s1;
				v_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s2 <= skid_v_q ? skid_q : qword;
			if (skid_v_q) skid_q <= qword;
		end else if (!skid_v_q) begin
			skid_q <= qword;
		end
		if (!in_stall) begin
			bits_s1 <= sample_bits;
			mute_s1 <= mute;
		end
	end

	assign out_valid = v_s2;
	assign pcm_word  = word_s2;

endmodule
`default_nettype wire

// ===== hdl/ftpq_checker.sv =====
// Port-level checker for the quantiser core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ftpq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] pcm_word,
	input wire logic        pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pcm_word))
		else $error("stalled beat changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_nostall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall ##1 !out_stall |=> !in_stall)
		else $error("input stalled without output backpressure");

	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall ##1 !out_stall |=> out_valid)
		else $error("result missing");

endmodule

bind float_to_pcm_quantizer_core ftpq_checker u_ftpq_checker (.*);
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the float to PCM quantiser core
`timescale 1ns / 1ps
module testbench;
	import ftpq_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] sample_bits = '0;
	logic        mute = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] pcm_word;

	fmt_t        cur_fmt = FMT_FLOAT;
	logic [31:0] pcm_pending[$];
	int          mismatches = 0;
	int          beats_sent = 0;
	int          beats_seen = 0;
	bit          quiet_mode = 1'b0;

	always #1 clk = ~clk;

	float_to_pcm_quantizer_core dut (.*);

	// Round to nearest even and saturate |x| * 2^k into a signed k+1 bit range.
	function automatic logic [31:0] quantise(logic [31:0] bits, int k);
		f32_t        f;
		logic [63:0] pos_lim, neg_lim, mag, q, rem, half;
		logic [31:0] m;
		int          e, sh, n;
		f = bits;
		pos_lim = (64'd1 << k) - 64'd1;
		neg_lim = 64'd1 << k;
		if (f.expo == 8'hFF) begin
			if (f.man != 0)
				return 32'd0;
			mag = neg_lim + 64'd1;
		end else begin
			if (f.expo == 8'd0) begin
				m = {9'd0, f.man};
				e = -149;
			end else begin
				m = {9'd1, f.man};
				e = int'(f.expo) - 150;
			end
			if (m == 0)
				return 32'd0;
			sh = e + k;
			if (sh >= 32) begin
				mag = neg_lim + 64'd1;
			end else if (sh >= 0) begin
				mag = {32'd0, m} << sh;
			end else begin
				n = -sh;
				if (n > 25) begin
					mag = 64'd0;
				end else begin
					q = {32'd0, m} >> n;
					rem = {32'd0, m} & ((64'd1 << n) - 64'd1);
					half = 64'd1 << (n - 1);
					if (rem > half || (rem == half && q[0]))
						q = q + 64'd1;
					mag = q;
				end
			end
		end
		if (f.neg) begin
			if (mag > neg_lim)
				mag = neg_lim;
			return 32'd0 - mag[31:0];
		end
		if (mag > pos_lim)
			mag = pos_lim;
		return mag[31:0];
	endfunction

	function automatic logic [31:0] pcm_of(logic [31:0] bits, logic mt);
		if (mt)
			return 32'd0;
		case (cur_fmt)
			FMT_FLOAT: return bits;
			FMT_S32:   return quantise(bits, 31);
			FMT_S24:   return quantise(bits, 23);
			default:   return quantise(bits, 15);
		endcase
	endfunction

	task automatic write_format(fmt_t fmt);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_OUT_FMT;
		pwdata <= {30'd0, fmt};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_fmt = fmt;
	endtask

	// Drive one beat, sometimes after a random gap outside quiet mode, and hold until accepted.
	task automatic send_sample(logic [31:0] bits, logic mt);
		int gap;
		if (!quiet_mode && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_bits <= bits;
		mute <= mt;
		pcm_pending.push_back(pcm_of(bits, mt));
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pcm_pending.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Output side: random stall bursts outside quiet mode, then compare each beat.
	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (quiet_mode) begin
				out_stall <= 1'b0;
			end else if (burst > 0) begin
				burst--;
				if (burst == 0)
					out_stall <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 8);
				out_stall <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			beats_seen++;
			if (pcm_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat pcm_word=%h", pcm_word);
			end else begin
				if (pcm_word !== pcm_pending[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch fmt=%0d expected=%h actual=%h",
							cur_fmt, pcm_pending[0], pcm_word);
				end
				void'(pcm_pending.pop_front());
			end
		end
	end

	function automatic logic [31:0] random_sample();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 5))
			0: v[30:23] = 8'hFF;
			1: v[30:23] = 8'($urandom_range(0, 3));
			2, 3: v[30:23] = 8'($urandom_range(100, 127));
			4: v[30:23] = 8'($urandom_range(127, 160));
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_reset_passthrough();
		send_sample(32'h3F80_0000, 1'b0);
		send_sample(32'h7FC0_0001, 1'b0);
		drain();
	endtask

	task automatic test_directed();
		logic [31:0] pts[$];
		pts = {32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
			32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h3F00_0000, 32'h3F7F_FFFF,
			32'h3800_0000, 32'h3800_0001, 32'h3840_0000, 32'h4F00_0000,
			32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3780_0000, 32'h3000_0000,
			32'h3F00_0001};
		for (int f = 0; f < 4; f++) begin
			write_format(fmt_t'(f));
			foreach (pts[i])
				send_sample(pts[i], 1'b0);
			send_sample(32'h3F00_0000, 1'b1);
			send_sample(32'hFFFF_FFFF, 1'b1);
			drain();
		end
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 125 == 0) begin
				drain();
				write_format(fmt_t'($urandom_range(0, 3)));
			end
			send_sample(($urandom_range(0, 9) == 0) ? $urandom : random_sample(),
				$urandom_range(0, 15) == 0);
		end
		drain();
	endtask

	task automatic test_back_to_back();
		quiet_mode = 1'b1;
		write_format(FMT_S16);
		for (int i = 0; i < 100; i++)
			send_sample(random_sample(), 1'b0);
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_passthrough();
		test_directed();
		test_random(800);
		test_back_to_back();
		$display("covered all four formats, mute, NaN, infinity, subnormals, ties");
		$display("%0d beats sent, %0d beats checked", beats_sent, beats_seen);
		if (mismatches == 0 && pcm_pending.size() == 0)
			$display("PASS float_to_pcm_quantizer_core");
		else
			$display("FAIL float_to_pcm_quantizer_core");
		$finish;
	end

	initial begin
		#200000;
		$display("FAIL float_to_pcm_quantizer_core");
		$finish;
	end

endmodule
